>>> rtl/core/rrq_pkg.sv
// shared types, codes and reset values for the round-robin run queue
package rrq_pkg;

  // default sizes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_TASK_BITS   = 8;

  // command codes
  localparam logic [2:0] CMD_ENQUEUE  = 3'd0;
  localparam logic [2:0] CMD_DEQUEUE  = 3'd1;
  localparam logic [2:0] CMD_PICK     = 3'd2;
  localparam logic [2:0] CMD_PUT_BACK = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  // register indexes
  localparam logic [1:0] REG_SLICE_TICKS      = 2'd0;
  localparam logic [1:0] REG_REBALANCE_PERIOD = 2'd1;
  localparam logic [1:0] REG_FIRST_REBALANCE  = 2'd2;

  // register reset values
  localparam logic [15:0] SLICE_TICKS_RST      = 16'd10;
  localparam logic [15:0] REBALANCE_PERIOD_RST = 16'd50;
  localparam logic [15:0] FIRST_REBALANCE_RST  = 16'd50;

  // request and result payloads
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] task_id;
  } rrq_req_t;

  typedef struct packed {
    logic [7:0] picked_task;
    logic       picked_valid;
    logic       do_resched;
    logic       need_balance;
    logic [4:0] queued_count;
    logic [1:0] status;
  } rrq_rsp_t;

  // per-cycle operation on the slot chain
  typedef struct packed {
    logic shift;
    logic load;
  } rrq_cell_op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_HEAD,
    ST_DONE
  } rrq_state_t;

endpackage

>>> rtl/core/rrq_cell.sv
// one queue slot: loads a new task or takes its right neighbor's task
module rrq_cell import rrq_pkg::*; #(
  parameter int TASK_BITS = DEF_TASK_BITS
) (
  input  logic                 clk,
  input  rrq_cell_op_t         op,
  input  logic [TASK_BITS-1:0] next_slot,
  input  logic [TASK_BITS-1:0] load_data,
  output logic [TASK_BITS-1:0] slot
);

  // load wins over the shift toward the head
  always_ff @(posedge clk) begin
    if (op.load) begin
      slot <= load_data;
    end else if (op.shift) begin
      slot <= next_slot;
    end
  end

endmodule

>>> rtl/core/rrq_chain.sv
// row of queue slots, shifting toward the head with one indexed load
module rrq_chain import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TASK_BITS   = DEF_TASK_BITS,
  localparam int POS_BITS   = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk,
  input  rrq_cell_op_t         op,
  input  logic [POS_BITS-1:0]  load_pos,
  input  logic [TASK_BITS-1:0] load_data,
  output logic [TASK_BITS-1:0] head
);

  logic [TASK_BITS-1:0] slots [QUEUE_DEPTH];

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      rrq_cell_op_t         cell_op;
      logic [TASK_BITS-1:0] right;

      // each cell decodes its own position
      assign cell_op.shift = op.shift;
      assign cell_op.load  = op.load && (load_pos == POS_BITS'(i));

      // last cell keeps its task on a shift
      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign right = slots[i];
      end else begin : g_mid
        assign right = slots[i+1];
      end

      rrq_cell #(
        .TASK_BITS (TASK_BITS)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op),
        .next_slot (right),
        .load_data (load_data),
        .slot      (slots[i])
      );
    end
  endgenerate

  assign head = slots[0];

endmodule

>>> rtl/core/round_robin_run_queue.sv
// round-robin run queue top level: controller, counters and slot chain
//
// Usage: a request (command, task_id) enters on req when req_valid is high
// and req_stall is low. Exactly one result per request leaves on rsp, held
// in an output register until rsp_valid is high with rsp_stall low. A new
// request is taken while an earlier result still waits in that register.
// Registers are written on the cfg port (cfg_ready is always high); the
// user must write them only while the block is idle, which the block does
// not enforce; index 0 slice_ticks, 1 rebalance_period, 2 first_rebalance.
// Enqueue, tick and unknown commands go from idle straight to the final
// state, which loads the output register; a pick of the head first passes
// the head state. Dequeue and put back rotate the whole queue through the
// slot chain, one slot per cycle, and put back moves the found task to the
// tail. A pick after an expired slice adds that same rotation. The next
// request is taken in the idle state that follows the loading of the result;
// the chain shift paces the searching commands. Reset empties the queue,
// clears the running task and loads the slice and rebalance counters from
// the register reset values. A stalled receiver holds the result; the next
// request then waits in its final state.
module round_robin_run_queue import rrq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int TASK_BITS   = DEF_TASK_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  rrq_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rrq_rsp_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int POS_BITS = $clog2(QUEUE_DEPTH);
  localparam int LEN_BITS = $clog2(QUEUE_DEPTH + 1);

  // control state
  rrq_state_t           state, state_next;
  logic [LEN_BITS-1:0]  len, len_next;
  logic [TASK_BITS-1:0] running_task, running_task_next;
  logic                 running_valid, running_valid_next;
  logic [15:0]          slice_left, slice_left_next;
  logic                 slice_expired, slice_expired_next;
  logic [15:0]          rebalance_left, rebalance_left_next;
  logic                 balance_flag, balance_flag_next;
  logic [15:0]          slice_ticks, rebalance_period, first_rebalance;

  // per-request working registers
  logic [2:0]           cmd, cmd_next;
  logic [TASK_BITS-1:0] key, key_next;
  logic [LEN_BITS-1:0]  scan_cnt, scan_cnt_next;
  logic                 found, found_next;
  logic [1:0]           status, status_next;
  logic                 resched, resched_next;
  logic                 seen_balance, seen_balance_next;

  // chain interface
  rrq_cell_op_t         chain_op;
  logic [POS_BITS-1:0]  load_pos;
  logic [TASK_BITS-1:0] load_data;
  logic [TASK_BITS-1:0] head;

  logic [TASK_BITS-1:0] req_task;
  logic [15:0]          reb_dec;
  logic                 hit;
  logic                 found_final;
  logic                 rsp_load;

  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign req_task  = TASK_BITS'(req.task_id);
  assign reb_dec   = rebalance_left - 16'd1;
  assign hit       = !found && (head == key);
  assign found_final = found || hit;
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  rrq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_BITS   (TASK_BITS)
  ) u_chain (
    .clk       (clk),
    .op        (chain_op),
    .load_pos  (load_pos),
    .load_data (load_data),
    .head      (head)
  );

  // next state and chain control
  always_comb begin
    state_next          = state;
    len_next            = len;
    running_task_next   = running_task;
    running_valid_next  = running_valid;
    slice_left_next     = slice_left;
    slice_expired_next  = slice_expired;
    rebalance_left_next = rebalance_left;
    balance_flag_next   = balance_flag;
    cmd_next            = cmd;
    key_next            = key;
    scan_cnt_next       = scan_cnt;
    found_next          = found;
    status_next         = status;
    resched_next        = resched;
    seen_balance_next   = seen_balance;
    chain_op            = '0;
    load_pos            = '0;
    load_data           = key;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd_next          = req.command;
          key_next          = req_task;
          status_next       = STAT_OK;
          resched_next      = 1'b0;
          seen_balance_next = balance_flag;
          state_next        = ST_DONE;
          unique case (req.command) inside
            CMD_ENQUEUE: begin
              if (len == LEN_BITS'(QUEUE_DEPTH)) begin
                status_next = STAT_FULL;
              end else begin
                chain_op.load = 1'b1;
                load_pos      = POS_BITS'(len);
                load_data     = req_task;
                len_next      = len + LEN_BITS'(1);
                // re-enqueue of the running task restarts its slice
                if (running_valid && running_task == req_task) begin
                  slice_left_next    = slice_ticks;
                  slice_expired_next = 1'b0;
                end
              end
            end
            CMD_DEQUEUE, CMD_PUT_BACK: begin
              if (len == '0) begin
                status_next = STAT_MISS;
              end else begin
                scan_cnt_next = len;
                found_next    = 1'b0;
                state_next    = ST_SCAN;
              end
            end
            CMD_PICK: begin
              // a pick reports the balance flag; if set, restarts the period
              if (balance_flag) begin
                balance_flag_next   = 1'b0;
                rebalance_left_next = rebalance_period;
              end
              if (len == '0) begin
                running_valid_next = 1'b0;
                status_next        = STAT_MISS;
              end else if (running_valid && slice_expired) begin
                key_next      = running_task;
                scan_cnt_next = len;
                found_next    = 1'b0;
                state_next    = ST_SCAN;
              end else begin
                state_next = ST_HEAD;
              end
            end
            CMD_TICK: begin
              if (running_valid) begin
                // rebalance countdown
                if (reb_dec == '0) begin
                  rebalance_left_next = rebalance_period;
                  balance_flag_next   = 1'b1;
                  resched_next        = 1'b1;
                end else begin
                  rebalance_left_next = reb_dec;
                end
                // slice countdown, reload once spent
                if (!slice_expired && slice_left != '0) begin
                  slice_left_next = slice_left - 16'd1;
                end else begin
                  slice_left_next = slice_ticks;
                  if (len > LEN_BITS'(1)) begin
                    resched_next       = 1'b1;
                    slice_expired_next = 1'b1;
                  end
                end
              end
              seen_balance_next = balance_flag_next;
            end
            default: begin
              status_next = STAT_MISS;
            end
          endcase
        end
      end

      // rotate one slot per cycle, dropping the first match
      ST_SCAN: begin
        chain_op.shift = 1'b1;
        if (hit) begin
          found_next = 1'b1;
          len_next   = len - LEN_BITS'(1);
        end else begin
          chain_op.load = 1'b1;
          load_pos      = POS_BITS'(len - LEN_BITS'(1));
          load_data     = head;
        end
        scan_cnt_next = scan_cnt - LEN_BITS'(1);
        if (scan_cnt == LEN_BITS'(1)) begin
          unique case (cmd) inside
            CMD_DEQUEUE: begin
              if (!found_final) begin
                status_next = STAT_MISS;
              end
              state_next = ST_DONE;
            end
            CMD_PUT_BACK: begin
              if (found_final) begin
                state_next = ST_APPEND;
              end else begin
                status_next = STAT_MISS;
                state_next  = ST_DONE;
              end
            end
            default: begin
              state_next = found_final ? ST_APPEND : ST_HEAD;
            end
          endcase
        end
      end

      // matched task goes back in at the tail
      ST_APPEND: begin
        chain_op.load = 1'b1;
        load_pos      = POS_BITS'(len);
        load_data     = key;
        len_next      = len + LEN_BITS'(1);
        state_next    = (cmd == CMD_PICK) ? ST_HEAD : ST_DONE;
      end

      // head task becomes current with a fresh slice
      ST_HEAD: begin
        running_task_next  = head;
        running_valid_next = 1'b1;
        slice_left_next    = slice_ticks;
        slice_expired_next = 1'b0;
        state_next         = ST_DONE;
      end

      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      len              <= '0;
      running_task     <= '0;
      running_valid    <= 1'b0;
      slice_left       <= SLICE_TICKS_RST;
      slice_expired    <= 1'b0;
      rebalance_left   <= FIRST_REBALANCE_RST;
      balance_flag     <= 1'b0;
      slice_ticks      <= SLICE_TICKS_RST;
      rebalance_period <= REBALANCE_PERIOD_RST;
      first_rebalance  <= FIRST_REBALANCE_RST;
      rsp_valid        <= 1'b0;
    end else begin
      state          <= state_next;
      len            <= len_next;
      running_task   <= running_task_next;
      running_valid  <= running_valid_next;
      slice_left     <= slice_left_next;
      slice_expired  <= slice_expired_next;
      rebalance_left <= rebalance_left_next;
      balance_flag   <= balance_flag_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SLICE_TICKS:      slice_ticks      <= cfg_data;
          REG_REBALANCE_PERIOD: rebalance_period <= cfg_data;
          REG_FIRST_REBALANCE:  first_rebalance  <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working registers and output register
  always_ff @(posedge clk) begin
    cmd          <= cmd_next;
    key          <= key_next;
    scan_cnt     <= scan_cnt_next;
    found        <= found_next;
    status       <= status_next;
    resched      <= resched_next;
    seen_balance <= seen_balance_next;
    if (rsp_load) begin
      rsp.picked_task  <= running_valid ? 8'(running_task) : 8'd0;
      rsp.picked_valid <= running_valid;
      rsp.do_resched   <= resched;
      rsp.need_balance <= seen_balance;
      rsp.queued_count <= 5'(len);
      rsp.status       <= status;
    end
  end

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_BITS'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  // an accepted request always leaves idle
  a_req_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != ST_IDLE))
    else $error("request accepted without work");

  // a new result only follows the final state
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_DONE))
    else $error("result without a finished request");

  // rotation never grows the queue
  a_scan_no_growth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (len <= $past(len)))
    else $error("queue grew during rotation");
`endif

endmodule
